// ===== design/edge_node_dedup_hash_macros.svh =====
// ----------------------------------------------------------------------------
// edge_node_dedup_hash assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef EDGE_NODE_DEDUP_HASH_MACROS_SVH
`define EDGE_NODE_DEDUP_HASH_MACROS_SVH

// same-cycle implication
`define EDH_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EDH_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/edh_pkg.sv =====
// ----------------------------------------------------------------------------
// edh_pkg
// Shared types and constants of the edge dedup hash table.
// ----------------------------------------------------------------------------
package edh_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int CFG_NODE_W = 16;
  localparam int CFG_LIM_W  = 15;

  // register indexes
  localparam logic [1:0] REG_NODE_START  = 2'd0;
  localparam logic [1:0] REG_OVF_START   = 2'd1;
  localparam logic [1:0] REG_TABLE_LIMIT = 2'd2;

  // reset values
  localparam logic [CFG_NODE_W-1:0] RST_NODE_START  = 16'd0;
  localparam logic [CFG_LIM_W-1:0]  RST_OVF_START   = 15'd8192;
  localparam logic [CFG_LIM_W-1:0]  RST_TABLE_LIMIT = 15'd16384;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CFG_NODE_W-1:0] node_count_start;
    logic [CFG_LIM_W-1:0]  overflow_start;
    logic [CFG_LIM_W-1:0]  table_limit;
    logic                  load_counter;
    logic                  load_free;
  } cfg_t;

endpackage

// ===== design/edh_in_if.sv =====
// ----------------------------------------------------------------------------
// edh_in_if
// Edge word channel: two vertex ids with valid/ready.
// ----------------------------------------------------------------------------
interface edh_in_if #(
  parameter int VERTEX_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [VERTEX_BITS-1:0] vertex_a;
  logic [VERTEX_BITS-1:0] vertex_b;

  modport source (output valid, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, output ready);
endinterface

// ===== design/edh_out_if.sv =====
// ----------------------------------------------------------------------------
// edh_out_if
// Result word channel: node number, new flag and status with valid/ready.
// ----------------------------------------------------------------------------
interface edh_out_if #(
  parameter int NODE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [NODE_BITS-1:0] node_number;
  logic                 is_new;
  logic [1:0]           status;

  modport source (output valid, output node_number, output is_new, output status,
                  input ready);
  modport sink   (input valid, input node_number, input is_new, input status,
                  output ready);
endinterface

// ===== design/edh_cfg.sv =====
// ----------------------------------------------------------------------------
// edh_cfg
// APB register file: node counter start, overflow pool start, table limit.
// ----------------------------------------------------------------------------
module edh_cfg
  import edh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CFG_NODE_W-1:0] node_count_start;
  logic [CFG_LIM_W-1:0]  overflow_start;
  logic [CFG_LIM_W-1:0]  table_limit;
  logic [1:0]            idx;
  logic                  wr;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count_start <= RST_NODE_START;
      overflow_start   <= RST_OVF_START;
      table_limit      <= RST_TABLE_LIMIT;
    end else if (wr) begin
      unique case (idx)
        REG_NODE_START:  node_count_start <= pwdata[CFG_NODE_W-1:0];
        REG_OVF_START:   overflow_start   <= pwdata[CFG_LIM_W-1:0];
        REG_TABLE_LIMIT: table_limit      <= pwdata[CFG_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NODE_START:  prdata = APB_DATA_W'(node_count_start);
      REG_OVF_START:   prdata = APB_DATA_W'(overflow_start);
      REG_TABLE_LIMIT: prdata = APB_DATA_W'(table_limit);
      default:         prdata = '0;
    endcase
  end

  // load values follow the write data so the walker loads at the write edge
  assign cfg.node_count_start = (wr && (idx == REG_NODE_START)) ?
                                pwdata[CFG_NODE_W-1:0] : node_count_start;
  assign cfg.overflow_start   = (wr && (idx == REG_OVF_START)) ?
                                pwdata[CFG_LIM_W-1:0] : overflow_start;
  assign cfg.table_limit      = table_limit;
  assign cfg.load_counter     = wr && (idx == REG_NODE_START);
  assign cfg.load_free        = wr && (idx == REG_OVF_START);

endmodule

// ===== design/edh_table.sv =====
// ----------------------------------------------------------------------------
// edh_table
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module edh_table #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 54,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/edh_walk.sv =====
// ----------------------------------------------------------------------------
// edh_walk
// Chain walker: clears the table, hashes edges, walks bucket chains,
// inserts new entries and holds the result word.
// ----------------------------------------------------------------------------
module edh_walk
  import edh_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16384,
  parameter int VERTEX_BITS   = 12,
  parameter int NODE_BITS     = 16,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES),
  parameter int WORD_W        = 2 * VERTEX_BITS + NODE_BITS + IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  edh_in_if.sink            edge_in,
  edh_out_if.source         node_out,
  output logic              mem_we,
  output logic [IDX_W-1:0]  mem_waddr,
  output logic [WORD_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [IDX_W-1:0]  mem_raddr,
  input  logic [WORD_W-1:0] mem_rdata
);

  localparam int LIM_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CW0   = (LIM_W > CFG_LIM_W) ? LIM_W : CFG_LIM_W;
  localparam int CMP_W = (CW0 > VERTEX_BITS + 1) ? CW0 : VERTEX_BITS + 1;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] lo;
    logic [VERTEX_BITS-1:0] hi;
    logic [NODE_BITS-1:0]   node;
    logic [IDX_W-1:0]       link;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FREE,
    S_LINK,
    S_RESP
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       clr_idx;
  logic [VERTEX_BITS-1:0] lo;
  logic [VERTEX_BITS-1:0] hi;
  logic [IDX_W-1:0]       cur;
  logic                   at_head;
  logic [CMP_W:0]         steps;
  entry_t                 tail;
  logic [NODE_BITS-1:0]   counter;
  logic [CMP_W-1:0]       next_free;
  logic [NODE_BITS-1:0]   res_node;
  logic                   res_new;
  logic [1:0]             res_status;
  logic                   out_valid;
  logic [NODE_BITS-1:0]   out_node;
  logic                   out_new;
  logic [1:0]             out_status;

  logic                   in_ready;
  logic                   in_fire;
  logic [CMP_W-1:0]       lim;
  logic [CMP_W-1:0]       sum_in;
  logic [VERTEX_BITS-1:0] lo_in;
  logic [VERTEX_BITS-1:0] hi_in;
  logic                   bad_in;
  entry_t                 rd;
  logic                   head_empty;
  logic                   hit;
  logic                   link_ok;
  logic [CMP_W:0]         steps_inc;
  logic                   over;
  logic                   cnt_full;
  logic                   free_bad;
  logic [IDX_W-1:0]       nf_idx;
  logic [NODE_BITS-1:0]   cnt_inc;
  entry_t                 new_word;
  entry_t                 link_word;
  logic                   out_free;

  assign in_ready      = (state == S_IDLE);
  assign edge_in.ready = in_ready;
  assign in_fire       = edge_in.valid && in_ready;

  assign lim = (CMP_W'(cfg.table_limit) < CMP_W'(TABLE_ENTRIES)) ?
               CMP_W'(cfg.table_limit) : CMP_W'(TABLE_ENTRIES);

  assign sum_in = CMP_W'(edge_in.vertex_a) + CMP_W'(edge_in.vertex_b);
  assign lo_in  = (edge_in.vertex_a < edge_in.vertex_b) ? edge_in.vertex_a : edge_in.vertex_b;
  assign hi_in  = (edge_in.vertex_a < edge_in.vertex_b) ? edge_in.vertex_b : edge_in.vertex_a;
  assign bad_in = (sum_in >= lim) || (lo_in == '0);

  assign rd         = entry_t'(mem_rdata);
  assign head_empty = at_head && (rd.lo == '0);
  assign hit        = (rd.lo == lo) && (rd.hi == hi);
  assign link_ok    = (rd.link != '0) && (CMP_W'(rd.link) < lim);
  assign steps_inc  = steps + (CMP_W + 1)'(1);
  assign over       = steps_inc > {1'b0, lim};
  assign cnt_full   = (counter == {NODE_BITS{1'b1}});
  assign free_bad   = cnt_full || (next_free == '0) || (next_free >= lim);
  assign nf_idx     = next_free[IDX_W-1:0];
  assign cnt_inc    = counter + NODE_BITS'(1);
  assign out_free   = !out_valid || node_out.ready;

  always_comb begin
    new_word.lo   = lo;
    new_word.hi   = hi;
    new_word.node = cnt_inc;
    new_word.link = '0;
    link_word      = tail;
    link_word.link = nf_idx;
  end

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cur;
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = WORD_W'(new_word);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_re    = in_fire && !bad_in;
        mem_raddr = sum_in[IDX_W-1:0];
      end
      S_CHECK: begin
        if (head_empty) begin
          mem_we = !cnt_full;
        end else if (!hit && link_ok) begin
          mem_re    = !over;
          mem_raddr = rd.link;
        end else if (!hit) begin
          mem_re    = !free_bad;
          mem_raddr = nf_idx;
        end
      end
      S_FREE: begin
        mem_we    = (rd.lo == '0);
        mem_waddr = nf_idx;
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = WORD_W'(link_word);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      counter   <= NODE_BITS'(RST_NODE_START);
      next_free <= CMP_W'(RST_OVF_START);
    end else begin
      if (node_out.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      if (cfg.load_counter) begin
        counter <= NODE_BITS'(cfg.node_count_start);
      end
      if (cfg.load_free) begin
        next_free <= CMP_W'(cfg.overflow_start);
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            lo      <= lo_in;
            hi      <= hi_in;
            cur     <= sum_in[IDX_W-1:0];
            at_head <= 1'b1;
            steps   <= '0;
            if (bad_in) begin
              res_node   <= '0;
              res_new    <= 1'b0;
              res_status <= ST_RANGE;
              state      <= S_RESP;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (head_empty) begin
            if (cnt_full) begin
              res_node   <= '0;
              res_new    <= 1'b0;
              res_status <= ST_FULL;
            end else begin
              counter    <= cnt_inc;
              res_node   <= cnt_inc;
              res_new    <= 1'b1;
              res_status <= ST_OK;
            end
            state <= S_RESP;
          end else if (hit) begin
            res_node   <= rd.node;
            res_new    <= 1'b0;
            res_status <= ST_OK;
            state      <= S_RESP;
          end else if (link_ok) begin
            if (over) begin
              res_node   <= '0;
              res_new    <= 1'b0;
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              steps   <= steps_inc;
              cur     <= rd.link;
              at_head <= 1'b0;
            end
          end else begin
            tail <= rd;
            if (free_bad) begin
              res_node   <= '0;
              res_new    <= 1'b0;
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              state <= S_FREE;
            end
          end
        end
        S_FREE: begin
          if (rd.lo != '0) begin
            res_node   <= '0;
            res_new    <= 1'b0;
            res_status <= ST_FULL;
            state      <= S_RESP;
          end else begin
            counter    <= cnt_inc;
            res_node   <= cnt_inc;
            res_new    <= 1'b1;
            res_status <= ST_OK;
            state      <= S_LINK;
          end
        end
        S_LINK: begin
          next_free <= next_free + CMP_W'(1);
          state     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_node   <= res_node;
            out_new    <= res_new;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign node_out.valid       = out_valid;
  assign node_out.node_number = out_node;
  assign node_out.is_new      = out_new;
  assign node_out.status      = out_status;

endmodule

// ===== design/edge_node_dedup_hash.sv =====
// ----------------------------------------------------------------------------
// edge_node_dedup_hash
// Assigns one node number per distinct undirected edge using a chained
// hash table held in a single-port-write synchronous memory.
// ----------------------------------------------------------------------------
// channel    dir  handshake          word
// edge_in    in   valid/ready        vertex_a, vertex_b
// node_out   out  valid/ready        node_number, is_new, status
// apb        in   psel/penable       paddr, pwdata -> prdata
//
// One edge at a time: a bucket-head hit or head insert passes through the
// check and result states, each chain entry walked repeats the check state,
// and an overflow insert adds the free-slot check and the link write.
// After reset the table is cleared entry by entry; edge_in.ready
// stays low meanwhile. A result word waits in the output register while
// node_out is stalled; the next edge is taken during that wait.
// ----------------------------------------------------------------------------
module edge_node_dedup_hash
  import edh_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16384,
  parameter int VERTEX_BITS   = 12,
  parameter int NODE_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  edh_in_if.sink                edge_in,
  edh_out_if.source             node_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int WORD_W = 2 * VERTEX_BITS + NODE_BITS + IDX_W;

  cfg_t              cfg;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  edh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  edh_walk #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VERTEX_BITS   (VERTEX_BITS),
    .NODE_BITS     (NODE_BITS),
    .IDX_W         (IDX_W),
    .WORD_W        (WORD_W)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .edge_in   (edge_in),
    .node_out  (node_out),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  edh_table #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== design/edh_checker.sv =====
// ----------------------------------------------------------------------------
// edh_checker
// Port-level checks of the edge dedup hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "edge_node_dedup_hash_macros.svh"

module edh_checker
  import edh_pkg::*;
#(
  parameter int NODE_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [NODE_BITS-1:0] node_number,
  input logic                 is_new,
  input logic [1:0]           status
);

  `EDH_ASSERT_IMP(a_err_zero, clk, rst, out_valid && status != ST_OK, node_number == '0 && !is_new, "error word carries data")
  `EDH_ASSERT_IMP(a_new_nonzero, clk, rst, out_valid && is_new, node_number != '0 && status == ST_OK, "bad new node")
  `EDH_ASSERT_NXT(a_one_at_time, clk, rst, in_valid && in_ready, !in_ready, "edge taken while busy")
  `EDH_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(node_number) && $stable(status) && $stable(is_new), "stalled word changed")

endmodule

bind edge_node_dedup_hash edh_checker #(
  .NODE_BITS (NODE_BITS)
) u_edh_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (edge_in.valid),
  .in_ready    (edge_in.ready),
  .out_valid   (node_out.valid),
  .out_ready   (node_out.ready),
  .node_number (node_out.node_number),
  .is_new      (node_out.is_new),
  .status      (node_out.status)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: edge dedup hash table testbench
// Feeds vertex-pair words into edge_node_dedup_hash under several register
// settings. A shadow table predicts each node word, including inserts, hits,
// chained overflow, range rejects and pool/counter exhaustion. Results are
// checked field by field, in order, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import edh_pkg::*;

  localparam int TABLE_ENTRIES = 16384;
  localparam int VERTEX_BITS   = 12;
  localparam int NODE_BITS     = 16;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] a;
    logic [VERTEX_BITS-1:0] b;
  } edge_pair_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] node;
    logic                 is_new;
    logic [1:0]           status;
  } node_word_t;

  // shadow of the hash table plus the queue of node words still owed
  class edge_node_tracker;
    bit [VERTEX_BITS-1:0] low_v   [TABLE_ENTRIES];
    bit [VERTEX_BITS-1:0] high_v  [TABLE_ENTRIES];
    bit [NODE_BITS-1:0]   node_of [TABLE_ENTRIES];
    bit [13:0]            link_of [TABLE_ENTRIES];
    int unsigned          next_free;
    bit [NODE_BITS-1:0]   counter;
    int unsigned          limit_reg;
    node_word_t           owed_nodes[$];
    int                   errors;
    int                   n_inserted;
    int                   n_found;
    int                   n_range;
    int                   n_full;

    function new();
      limit_reg = 32'(RST_TABLE_LIMIT);
      next_free = 32'(RST_OVF_START);
      counter   = RST_NODE_START;
    endfunction

    function void configure(logic [1:0] idx, int unsigned value);
      case (idx)
        REG_NODE_START:  counter   = value[NODE_BITS-1:0];
        REG_OVF_START:   next_free = value & 32'h7FFF;
        REG_TABLE_LIMIT: limit_reg = value & 32'h7FFF;
        default: ;
      endcase
    endfunction

    function void put_entry(int unsigned idx, bit [VERTEX_BITS-1:0] lo,
                            bit [VERTEX_BITS-1:0] hi);
      counter       = counter + NODE_BITS'(1);
      low_v[idx]    = lo;
      high_v[idx]   = hi;
      node_of[idx]  = counter;
      link_of[idx]  = '0;
    endfunction

    function node_word_t resolve_edge(logic [VERTEX_BITS-1:0] a,
                                      logic [VERTEX_BITS-1:0] b);
      int unsigned          lim, sum, cur, steps;
      bit [VERTEX_BITS-1:0] lo, hi;
      node_word_t           r;
      r   = '0;
      lim = (limit_reg < TABLE_ENTRIES) ? limit_reg : TABLE_ENTRIES;
      sum = 32'(a) + 32'(b);
      lo  = (a < b) ? a : b;
      hi  = (a < b) ? b : a;
      if (sum >= lim || lo == 0) begin
        r.status = ST_RANGE;
        return r;
      end
      cur = sum;
      if (low_v[cur] == 0) begin
        if (counter == '1) begin
          r.status = ST_FULL;
          return r;
        end
        put_entry(cur, lo, hi);
        r.node   = counter;
        r.is_new = 1'b1;
        return r;
      end
      if (low_v[cur] == lo && high_v[cur] == hi) begin
        r.node = node_of[cur];
        return r;
      end
      steps = 0;
      while (link_of[cur] != 0 && link_of[cur] < lim) begin
        steps++;
        if (steps > lim) begin
          r.status = ST_FULL;
          return r;
        end
        cur = 32'(link_of[cur]);
        if (low_v[cur] == lo && high_v[cur] == hi) begin
          r.node = node_of[cur];
          return r;
        end
      end
      if (counter == '1 || next_free == 0 || next_free >= lim ||
          low_v[next_free] != 0) begin
        r.status = ST_FULL;
        return r;
      end
      link_of[cur] = 14'(next_free);
      put_entry(next_free, lo, hi);
      next_free = next_free + 1;
      r.node    = counter;
      r.is_new  = 1'b1;
      return r;
    endfunction

    function void note_edge(logic [VERTEX_BITS-1:0] a, logic [VERTEX_BITS-1:0] b);
      node_word_t r;
      r = resolve_edge(a, b);
      owed_nodes.push_back(r);
      if (r.status == ST_RANGE) n_range++;
      else if (r.status == ST_FULL) n_full++;
      else if (r.is_new) n_inserted++;
      else n_found++;
    endfunction

    function void check_node(node_word_t act);
      node_word_t exp_w;
      if (owed_nodes.size() == 0) begin
        $display("%0t: unexpected node word node=%0d is_new=%0d status=%0d",
                 $time, act.node, act.is_new, act.status);
        errors++;
        return;
      end
      exp_w = owed_nodes.pop_front();
      if (act.node !== exp_w.node) begin
        $display("%0t: node_number expected %0d actual %0d", $time, exp_w.node, act.node);
        errors++;
      end
      if (act.is_new !== exp_w.is_new) begin
        $display("%0t: is_new expected %0d actual %0d", $time, exp_w.is_new, act.is_new);
        errors++;
      end
      if (act.status !== exp_w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_w.status, act.status);
        errors++;
      end
    endfunction

    function int pending();
      return owed_nodes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  edh_in_if  #(.VERTEX_BITS(VERTEX_BITS)) edge_ch ();
  edh_out_if #(.NODE_BITS(NODE_BITS))     node_ch ();

  edge_node_dedup_hash #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .VERTEX_BITS  (VERTEX_BITS),
    .NODE_BITS    (NODE_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .edge_in (edge_ch),
    .node_out(node_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  edge_node_tracker tracker;
  edge_pair_t       seen_edges[$];
  int               stall_pct;
  int unsigned      cycle_count;
  int               n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d node words outstanding",
               cycle_count, tracker.pending());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (edge_ch.valid && edge_ch.ready)
        tracker.note_edge(edge_ch.vertex_a, edge_ch.vertex_b);
      if (node_ch.valid && node_ch.ready)
        tracker.check_node('{node: node_ch.node_number, is_new: node_ch.is_new,
                             status: node_ch.status});
    end
  end

  // sink side: random stall bursts
  initial begin
    node_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        node_ch.ready = 1'b0;
        repeat ($urandom_range(6, 1) - 1) @(negedge clk);
      end else begin
        node_ch.ready = 1'b1;
      end
    end
  end

  function automatic edge_pair_t pick_edge(int small_max);
    edge_pair_t p;
    int         r;
    r = $urandom_range(99);
    if (r < 35 && seen_edges.size() > 0) begin
      p = seen_edges[$urandom_range(seen_edges.size() - 1)];
      if ($urandom_range(1)) p = '{a: p.b, b: p.a};
      return p;
    end
    if (r < 75) begin
      p.a = VERTEX_BITS'($urandom_range(small_max, 1));
      p.b = VERTEX_BITS'($urandom_range(small_max, 1));
    end else if (r < 96) begin
      p.a = VERTEX_BITS'($urandom_range(4095, 1));
      p.b = VERTEX_BITS'($urandom_range(4095, 1));
    end else begin
      p.a = VERTEX_BITS'($urandom_range(4095));
      p.b = VERTEX_BITS'($urandom_range(4095));
      if ($urandom_range(1)) p.a = '0;
      else p.b = '0;
    end
    seen_edges.push_back(p);
    if (seen_edges.size() > 256) void'(seen_edges.pop_front());
    return p;
  endfunction

  task automatic drive_one(input edge_pair_t p, input int idle_pct);
    int gap;
    gap = (idle_pct > 0 && $urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      edge_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    edge_ch.valid    = 1'b1;
    edge_ch.vertex_a = p.a;
    edge_ch.vertex_b = p.b;
    do @(posedge clk); while (!edge_ch.ready);
  endtask

  task automatic send_random(input int count, input int small_max, input int idle_pct);
    for (int i = 0; i < count; i++)
      drive_one(pick_edge(small_max), idle_pct);
    @(negedge clk);
    edge_ch.valid = 1'b0;
  endtask

  task automatic reg_write(input logic [1:0] idx, input int unsigned value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.configure(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle(input int tail);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_registers(input int unsigned node_start, input int unsigned ovf,
                               input int unsigned lim);
    settle(8);
    reg_write(REG_NODE_START, node_start);
    reg_write(REG_OVF_START, ovf);
    reg_write(REG_TABLE_LIMIT, lim);
    n_settings++;
  endtask

  initial begin
    edge_pair_t directed[$];
    tracker          = new();
    rst              = 1'b1;
    stall_pct        = 0;
    edge_ch.valid    = 1'b0;
    edge_ch.vertex_a = '0;
    edge_ch.vertex_b = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // table clear runs after reset
    while (!edge_ch.ready) @(posedge clk);

    // head insert/hit, swapped order, chained insert and hit, zero endpoints
    set_registers(0, 8192, 16384);
    directed = '{
      '{12'd1, 12'd1},       '{12'd1, 12'd1},       '{12'd4095, 12'd4095},
      '{12'd4095, 12'd1},    '{12'd1, 12'd4095},    '{12'd2, 12'd3},
      '{12'd3, 12'd2},       '{12'd1, 12'd4},       '{12'd4, 12'd1},
      '{12'd0, 12'd5},       '{12'd5, 12'd0},       '{12'd0, 12'd0},
      '{12'hAAA, 12'h555},   '{12'h555, 12'hAAA},   '{12'h800, 12'h7FF},
      '{12'h7FF, 12'h800},   '{12'd2, 12'd4},       '{12'd1, 12'd5},
      '{12'd3, 12'd3},       '{12'd5, 12'd1}
    };
    foreach (directed[i]) drive_one(directed[i], 0);
    @(negedge clk);
    edge_ch.valid = 1'b0;

    stall_pct = 30;
    send_random(250, 48, 30);
    stall_pct = 0;
    send_random(250, 48, 0);

    // counter saturates after a few inserts; pool start already occupied
    set_registers(65530, 8192, 16384);
    stall_pct = 25;
    send_random(120, 48, 25);

    // pool start at the limit: chained inserts must fail
    set_registers(100, 16384, 16384);
    send_random(200, 48, 20);

    // shrunk limit: range rejects and stale links into the old pool
    set_registers(200, 4000, 4100);
    stall_pct = 40;
    send_random(200, 60, 40);

    // tiny table, pool at entry 1
    set_registers(1000, 1, 16);
    stall_pct = 20;
    send_random(150, 7, 20);

    // limit 1 rejects everything
    set_registers(65535, 16384, 1);
    send_random(50, 48, 30);

    // closing stretch at full rate
    set_registers(300, 12000, 16384);
    stall_pct = 0;
    send_random(260, 64, 0);

    settle(40);
    $display("Checked %0d node words over %0d register settings:", tracker.n_inserted +
             tracker.n_found + tracker.n_range + tracker.n_full, n_settings);
    $display("  %0d inserted, %0d found, %0d range rejects, %0d full rejects",
             tracker.n_inserted, tracker.n_found, tracker.n_range, tracker.n_full);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
